>>> rtl/afwc_pkg.sv
// Shared types, constants and window weight helper for the ADC frame window conditioner.
// Used by afwc_stats, afwc_window_dp and the top module; depends on nothing.
package afwc_pkg;

	// Default configuration.
	localparam int FRAME_LEN_DEF = 256;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int WINDOW_FRAC_BITS_DEF = 16;

	// Fixed port widths.
	localparam int SAMPLE_W = 12;
	localparam int POS_OUT_W = 8;
	localparam int WV_W = 21;
	localparam int MEAN_W = 20;
	localparam int STAT_W = 12;

	// Saturation limits of the result and of the Q12.8 mean.
	localparam int unsigned WV_LIMIT = 1048320;
	localparam int unsigned MEAN_MAX = (1 << MEAN_W) - 1;

	// Half of a 256-point Hann window in units of 1e-5; the other half is its mirror.
	localparam int ROM_LEN = 128;
	localparam int WEIGHT_SCALE = 100000;
	localparam int unsigned HANN_ROM [ROM_LEN] = '{
		0, 15, 61, 137, 243, 379, 545, 742,
		968, 1224, 1510, 1825, 2170, 2543, 2946, 3376,
		3836, 4323, 4838, 5380, 5949, 6546, 7168, 7817,
		8491, 9190, 9914, 10663, 11435, 12231, 13050, 13891,
		14754, 15638, 16543, 17469, 18414, 19379, 20362, 21363,
		22382, 23417, 24468, 25535, 26617, 27713, 28823, 29945,
		31079, 32225, 33382, 34549, 35725, 36910, 38103, 39303,
		40510, 41722, 42940, 44161, 45387, 46615, 47845, 49076,
		50308, 51540, 52771, 54000, 55226, 56450, 57670, 58885,
		60094, 61298, 62494, 63683, 64864, 66036, 67197, 68349,
		69489, 70618, 71734, 72837, 73926, 75000, 76059, 77103,
		78130, 79140, 80132, 81106, 82061, 82996, 83912, 84807,
		85681, 86533, 87363, 88170, 88954, 89714, 90451, 91163,
		91849, 92511, 93146, 93756, 94339, 94895, 95423, 95924,
		96398, 96843, 97259, 97647, 98006, 98336, 98636, 98907,
		99149, 99360, 99542, 99693, 99814, 99905, 99966, 99996
	};

	// Control flags that travel with a transaction from the statistics block into the datapath.
	typedef struct packed {
		logic valid;
		logic last;
		logic have;
	} afwc_ctl_t;

	// Window weight of ROM entry idx scaled to 2^frac, rounded to nearest.
	// Only ever evaluated on constants, so it folds away at elaboration.
	function automatic longint hann_weight(input int idx, input int frac);
		longint num;
		num = (longint'(HANN_ROM[idx]) << frac) + longint'(WEIGHT_SCALE / 2);
		return num / WEIGHT_SCALE;
	endfunction

endpackage

>>> rtl/afwc_frame_mem.sv
// Ping-pong frame store: one synchronous write port and one registered read port.
// Depends on nothing; sized by the parent.
module afwc_frame_mem #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while the pipeline is stalled.
	always_ff @(posedge clk) begin
		if (en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/afwc_stats.sv
// Write position, half select and running/completed frame statistics.
// Depends on afwc_pkg for the control struct.
module afwc_stats #(
	parameter int FRAME_LEN = afwc_pkg::FRAME_LEN_DEF,
	parameter int SAMPLE_BITS = afwc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [SAMPLE_BITS-1:0]           smp,
	output logic [$clog2(2*FRAME_LEN)-1:0]   waddr,
	output logic [$clog2(2*FRAME_LEN)-1:0]   raddr,
	output logic [$clog2(FRAME_LEN)-1:0]     pos,
	output afwc_pkg::afwc_ctl_t              ctl,
	output logic [SAMPLE_BITS+7:0]           done_sum,
	output logic [SAMPLE_BITS-1:0]           done_min,
	output logic [SAMPLE_BITS-1:0]           done_max
);
	import afwc_pkg::*;

	localparam int POS_W = $clog2(FRAME_LEN);
	localparam int AW = $clog2(2 * FRAME_LEN);
	localparam int SUM_W = SAMPLE_BITS + 8;

	logic [POS_W-1:0]       pos_q;
	logic                   half_q;
	logic                   have_q;
	logic [SUM_W-1:0]       run_sum_q;
	logic [SAMPLE_BITS-1:0] run_min_q;
	logic [SAMPLE_BITS-1:0] run_max_q;
	logic [SUM_W-1:0]       done_sum_q;
	logic [SAMPLE_BITS-1:0] done_min_q;
	logic [SAMPLE_BITS-1:0] done_max_q;
	logic                   last;
	logic [SUM_W-1:0]       sum_nx;
	logic [SAMPLE_BITS-1:0] min_nx;
	logic [SAMPLE_BITS-1:0] max_nx;
	logic [AW-1:0]          lo_addr;
	logic [AW-1:0]          hi_addr;

	assign last = (pos_q == POS_W'(FRAME_LEN - 1));
	assign lo_addr = AW'(pos_q);
	assign hi_addr = AW'(pos_q) + AW'(FRAME_LEN);

	// The half being filled is written; the other half holds the completed frame.
	assign waddr = half_q ? hi_addr : lo_addr;
	assign raddr = half_q ? lo_addr : hi_addr;

	assign sum_nx = run_sum_q + SUM_W'(smp);
	assign min_nx = (smp < run_min_q) ? smp : run_min_q;
	assign max_nx = (smp > run_max_q) ? smp : run_max_q;

	assign pos = pos_q;
	assign ctl = '{valid: accept, last: last, have: have_q};
	assign done_sum = done_sum_q;
	assign done_min = done_min_q;
	assign done_max = done_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			half_q <= 1'b0;
			have_q <= 1'b0;
			run_sum_q <= '0;
			run_min_q <= '1;
			run_max_q <= '0;
			done_sum_q <= '0;
			done_min_q <= '0;
			done_max_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				half_q <= ~half_q;
				have_q <= 1'b1;
				done_sum_q <= sum_nx;
				done_min_q <= min_nx;
				done_max_q <= max_nx;
				run_sum_q <= '0;
				run_min_q <= '1;
				run_max_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				run_sum_q <= sum_nx;
				run_min_q <= min_nx;
				run_max_q <= max_nx;
			end
		end
	end

endmodule

>>> rtl/afwc_window_dp.sv
// Mean, DC removal, Hann weighting and rounding pipeline with the output register.
// Depends on afwc_pkg for widths, limits, the control struct and the window weights.
module afwc_window_dp #(
	parameter int FRAME_LEN = afwc_pkg::FRAME_LEN_DEF,
	parameter int SAMPLE_BITS = afwc_pkg::SAMPLE_BITS_DEF,
	parameter int WINDOW_FRAC_BITS = afwc_pkg::WINDOW_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  afwc_pkg::afwc_ctl_t                ctl,
	input  logic [$clog2(FRAME_LEN)-1:0]       pos,
	input  logic [SAMPLE_BITS+7:0]             done_sum,
	input  logic [SAMPLE_BITS-1:0]             done_min,
	input  logic [SAMPLE_BITS-1:0]             done_max,
	input  logic [SAMPLE_BITS-1:0]             rdata,
	output logic                               res_valid,
	output logic [afwc_pkg::WV_W-1:0]          windowed_value,
	output logic                               out_valid,
	output logic [afwc_pkg::POS_OUT_W-1:0]     out_position,
	output logic                               frame_last,
	output logic [afwc_pkg::STAT_W-1:0]        frame_min,
	output logic [afwc_pkg::STAT_W-1:0]        frame_max,
	output logic [afwc_pkg::MEAN_W-1:0]        frame_mean_q8
);
	import afwc_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int W = WINDOW_FRAC_BITS;
	localparam int POS_W = $clog2(FRAME_LEN);
	localparam int SUM_W = SB + 8;
	localparam int NUM_W = SUM_W + 8;
	localparam int RCP_W = NUM_W - 3;
	localparam int QUO_W = NUM_W - 3;
	localparam int P_W = NUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << NUM_W) / FRAME_LEN);
	localparam int DW = ((SB + 8 > MEAN_W) ? SB + 8 : MEAN_W) + 1;
	localparam int MAG_W = DW - 1;
	localparam int PR_W = MAG_W + W;
	localparam int RND_W = PR_W - W + 1;
	localparam int TAB_N = 1 << POS_W;

	// Per-position weights, folded out of the mirrored ROM at elaboration.
	// The weight keeps one integer bit, since the peak rounds up to one at short fractions.
	logic [W:0] wtab [TAB_N];
	for (genvar gi = 0; gi < TAB_N; gi++) begin : g_wtab
		localparam int RAW = (gi * 255) / (FRAME_LEN - 1);
		localparam int IDX = (RAW > ROM_LEN - 1) ? ROM_LEN - 1 : RAW;
		localparam bit USED = (gi <= FRAME_LEN / 2);
		assign wtab[gi] = USED ? (W + 1)'(hann_weight(IDX, W)) : '0;
	end

	// Stage 1: snapshot alongside the store read.
	afwc_ctl_t          ctl_s1;
	logic [POS_W-1:0]   pos_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [SB-1:0]      min_s1;
	logic [SB-1:0]      max_s1;
	// Stage 2: reciprocal product for the mean.
	afwc_ctl_t          ctl_s2;
	logic [POS_W-1:0]   pos_s2;
	logic [NUM_W-1:0]   num_s2;
	logic [P_W-1:0]     prod_m_s2;
	logic [SB-1:0]      x_s2;
	logic [SB-1:0]      min_s2;
	logic [SB-1:0]      max_s2;
	// Stage 3: mean and window weight.
	afwc_ctl_t          ctl_s3;
	logic [POS_W-1:0]   pos_s3;
	logic [MEAN_W-1:0]  mean_s3;
	logic [W:0]         w_s3;
	logic [SB-1:0]      x_s3;
	logic [SB-1:0]      min_s3;
	logic [SB-1:0]      max_s3;
	// Stage 4: weighted magnitude.
	afwc_ctl_t          ctl_s4;
	logic [POS_W-1:0]   pos_s4;
	logic [MEAN_W-1:0]  mean_s4;
	logic [PR_W-1:0]    prod_s4;
	logic               neg_s4;
	logic [SB-1:0]      min_s4;
	logic [SB-1:0]      max_s4;

	logic [NUM_W-1:0]   num;
	logic [QUO_W-1:0]   quo0;
	logic [NUM_W-1:0]   rem;
	logic [QUO_W-1:0]   quo;
	logic [MEAN_W-1:0]  mean;
	logic [POS_W-1:0]   mirr;
	logic [DW-1:0]      diff;
	logic [MAG_W-1:0]   mag;
	logic [RND_W-1:0]   rnd;
	logic [WV_W-1:0]    sat;
	logic [WV_W-1:0]    wv;

	// mean = (sum * 256 + FRAME_LEN / 2) / FRAME_LEN by reciprocal multiply.
	// The truncated reciprocal undershoots by at most one, fixed by one compare.
	assign num = {sum_s1, 8'd0} + NUM_W'(FRAME_LEN / 2);
	assign quo0 = QUO_W'(prod_m_s2 >> NUM_W);
	assign rem = num_s2 - NUM_W'(quo0 * FRAME_LEN);
	assign quo = (rem >= NUM_W'(FRAME_LEN)) ? quo0 + QUO_W'(1) : quo0;
	assign mean = (quo > QUO_W'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX) : MEAN_W'(quo);

	assign mirr = (pos_s2 < POS_W'(FRAME_LEN / 2)) ? pos_s2 : POS_W'(FRAME_LEN - 1) - pos_s2;

	assign diff = DW'({x_s3, 8'd0}) - DW'(mean_s3);
	assign mag = diff[DW-1] ? MAG_W'(-diff) : MAG_W'(diff);

	// Round half away from zero on the magnitude, then saturate and restore the sign.
	assign rnd = RND_W'(((RND_W + W)'(prod_s4) + (RND_W + W)'(1 << (W - 1))) >> W);
	assign sat = (rnd > RND_W'(WV_LIMIT)) ? WV_W'(WV_LIMIT) : WV_W'(rnd);
	assign wv = neg_s4 ? WV_W'(-sat) : sat;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos;
			sum_s1 <= done_sum;
			min_s1 <= done_min;
			max_s1 <= done_max;

			pos_s2 <= pos_s1;
			num_s2 <= num;
			prod_m_s2 <= P_W'(num) * P_W'(RECIP);
			x_s2 <= rdata;
			min_s2 <= min_s1;
			max_s2 <= max_s1;

			pos_s3 <= pos_s2;
			mean_s3 <= mean;
			w_s3 <= wtab[mirr];
			x_s3 <= x_s2;
			min_s3 <= min_s2;
			max_s3 <= max_s2;

			pos_s4 <= pos_s3;
			mean_s4 <= mean_s3;
			prod_s4 <= PR_W'(mag) * PR_W'(w_s3);
			neg_s4 <= diff[DW-1];
			min_s4 <= min_s3;
			max_s4 <= max_s3;

			windowed_value <= ctl_s4.have ? wv : '0;
			out_valid <= ctl_s4.have;
			out_position <= POS_OUT_W'(pos_s4);
			frame_last <= ctl_s4.last;
			frame_min <= ctl_s4.have ? STAT_W'(min_s4) : '0;
			frame_max <= ctl_s4.have ? STAT_W'(max_s4) : '0;
			frame_mean_q8 <= ctl_s4.have ? mean_s4 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			res_valid <= 1'b0;
		end else if (en) begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			res_valid <= ctl_s4.valid;
		end
	end

endmodule

>>> rtl/adc_frame_window_conditioner.sv
// ADC frame window conditioner: DC removal and Hann windowing of ping-pong ADC frames.
// Each accepted sample transaction passes through the datapath stages and the output register.
// Throughput: one transaction per cycle unless the consumer stalls a finished result, set by the single
// write and single read port of the frame store and one window multiplier per sample.
// Reset: arst_n clears positions, statistics and pipeline valids; the frame store is not cleared.
// Depends on afwc_pkg, afwc_frame_mem, afwc_stats and afwc_window_dp.
module adc_frame_window_conditioner #(
	parameter int FRAME_LEN = afwc_pkg::FRAME_LEN_DEF,
	parameter int SAMPLE_BITS = afwc_pkg::SAMPLE_BITS_DEF,
	parameter int WINDOW_FRAC_BITS = afwc_pkg::WINDOW_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [afwc_pkg::SAMPLE_W-1:0]  sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [afwc_pkg::WV_W-1:0]      windowed_value,
	output logic                           out_valid,
	output logic [afwc_pkg::POS_OUT_W-1:0] out_position,
	output logic                           frame_last,
	output logic [afwc_pkg::STAT_W-1:0]    frame_min,
	output logic [afwc_pkg::STAT_W-1:0]    frame_max,
	output logic [afwc_pkg::MEAN_W-1:0]    frame_mean_q8
);
	import afwc_pkg::*;

	localparam int DEPTH = 2 * FRAME_LEN;
	localparam int AW = $clog2(DEPTH);
	localparam int POS_W = $clog2(FRAME_LEN);

	// The whole pipeline moves as one: it advances unless a finished result sits in the
	// output register and the consumer stalls it. Bubbles still flow while stalled-free,
	// so a new sample transaction is taken every cycle the output is free or being taken.
	logic                   en;
	logic                   accept;
	logic [SAMPLE_BITS-1:0] smp;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;
	logic [POS_W-1:0]       pos;
	afwc_ctl_t              ctl;
	logic [SAMPLE_BITS+7:0] done_sum;
	logic [SAMPLE_BITS-1:0] done_min;
	logic [SAMPLE_BITS-1:0] done_max;
	logic [SAMPLE_BITS-1:0] rdata;

	assign en = !(result_valid && result_stall);
	assign sample_stall = !en;
	assign accept = sample_valid && en;

	// Bits above SAMPLE_BITS are ignored; narrower inputs are zero extended.
	assign smp = SAMPLE_BITS'(sample);

	// Write position and frame statistics. At the last position of a half the running
	// sum, minimum and maximum, including that sample, become the completed frame's values.
	afwc_stats #(
		.FRAME_LEN  (FRAME_LEN),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.smp     (smp),
		.waddr   (waddr),
		.raddr   (raddr),
		.pos     (pos),
		.ctl     (ctl),
		.done_sum(done_sum),
		.done_min(done_min),
		.done_max(done_max)
	);

	// The sample is written into the half being filled while the same position of the
	// other half is read. The two addresses always lie in different halves, and the read
	// half was last written a full frame earlier, so no forwarding is needed.
	afwc_frame_mem #(
		.DEPTH(DEPTH),
		.WIDTH(SAMPLE_BITS)
	) u_mem (
		.clk  (clk),
		.en   (en),
		.we   (accept),
		.waddr(waddr),
		.wdata(smp),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Mean, DC removal, window multiply and rounding. Until a complete frame exists the
	// result carries zeros but still reports its position and the last-position flag.
	afwc_window_dp #(
		.FRAME_LEN       (FRAME_LEN),
		.SAMPLE_BITS     (SAMPLE_BITS),
		.WINDOW_FRAC_BITS(WINDOW_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.ctl           (ctl),
		.pos           (pos),
		.done_sum      (done_sum),
		.done_min      (done_min),
		.done_max      (done_max),
		.rdata         (rdata),
		.res_valid     (result_valid),
		.windowed_value(windowed_value),
		.out_valid     (out_valid),
		.out_position  (out_position),
		.frame_last    (frame_last),
		.frame_min     (frame_min),
		.frame_max     (frame_max),
		.frame_mean_q8 (frame_mean_q8)
	);

endmodule

>>> tb/adc_frame_window_conditioner_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for adc_frame_window_conditioner: directed samples and random ADC
// frames with random idling on both channels, checked against an in-bench windowing predictor.
// Depends on afwc_pkg and the RTL under rtl.
module adc_frame_window_conditioner_tb;
	import afwc_pkg::*;

	localparam int FRAME = FRAME_LEN_DEF;
	localparam int FRAC = WINDOW_FRAC_BITS_DEF;
	localparam int DIRECTED_COUNT = 22;
	localparam int RANDOM_COUNT = 630;
	// Quiet cycles that run after the last result has been delivered, before the final check.
	localparam int DRAIN_CYCLES = 20;
	// Longest correct quiet stretch is the largest random sender gap or receiver stall plus the
	// pipeline latency; the limit is taken many times over that.
	localparam int IDLE_LIMIT = 500;

	// Sample distributions that the random part switches between every 64 transactions.
	typedef enum int {
		MIX_UNIFORM,
		MIX_FULL_SCALE,
		MIX_ZERO,
		MIX_RAILS,
		MIX_NARROW
	} sample_mix_t;

	// One windowed output transaction as the block should present it.
	typedef struct packed {
		logic [WV_W-1:0]      wv;
		logic                 ov;
		logic [POS_OUT_W-1:0] pos;
		logic                 last;
		logic [STAT_W-1:0]    fmin;
		logic [STAT_W-1:0]    fmax;
		logic [MEAN_W-1:0]    mean;
	} window_result_t;

	// The scoreboard carries its own copy of the ping-pong store and the frame statistics.
	// Every accepted sample produces exactly one expected result, in order.
	class window_scoreboard;
		logic [SAMPLE_W-1:0] frame_store [2*FRAME];
		int                  wr_pos;
		logic [19:0]         run_sum;
		logic [STAT_W-1:0]   run_min;
		logic [STAT_W-1:0]   run_max;
		logic [19:0]         done_sum;
		logic [STAT_W-1:0]   done_min;
		logic [STAT_W-1:0]   done_max;
		logic                have_frame;
		window_result_t      expected_results [$];
		int                  errors;

		function new();
			foreach (frame_store[i]) frame_store[i] = '0;
			wr_pos = 0;
			run_sum = '0;
			run_min = '1;
			run_max = '0;
			done_sum = '0;
			done_min = '0;
			done_max = '0;
			have_frame = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Rounded Q12.8 mean of a completed frame.
		function logic [MEAN_W-1:0] frame_mean(logic [19:0] sum);
			longint m;
			m = ((longint'(sum) << 8) + FRAME / 2) / FRAME;
			if (m > MEAN_MAX) m = MEAN_MAX;
			return m[MEAN_W-1:0];
		endfunction

		// DC-removed sample times the mirrored Hann weight, rounded half away from zero.
		function logic [WV_W-1:0] hann_windowed(logic [SAMPLE_W-1:0] x, logic [MEAN_W-1:0] mean,
				int pos);
			int     m;
			int     idx;
			longint w;
			longint diff;
			longint mag;
			longint rnd;
			logic   neg;
			m = (pos < FRAME / 2) ? pos : FRAME - 1 - pos;
			idx = (m * 255) / (FRAME - 1);
			if (idx >= ROM_LEN) idx = ROM_LEN - 1;
			w = ((longint'(HANN_ROM[idx]) << FRAC) + WEIGHT_SCALE / 2) / WEIGHT_SCALE;
			diff = (longint'(x) << 8) - longint'(mean);
			neg = diff < 0;
			mag = neg ? -diff : diff;
			rnd = (mag * w + (longint'(1) << (FRAC - 1))) >> FRAC;
			if (rnd > WV_LIMIT) rnd = WV_LIMIT;
			if (neg) rnd = -rnd;
			return rnd[WV_W-1:0];
		endfunction

		// Accepted sample: predict its result from the other half, then update the store.
		function void note_sample(logic [SAMPLE_W-1:0] s);
			window_result_t r;
			int             pos;
			int             rd;
			logic           upper;
			logic [MEAN_W-1:0] mean;
			upper = wr_pos >= FRAME;
			pos = upper ? wr_pos - FRAME : wr_pos;
			rd = upper ? pos : pos + FRAME;
			r = '0;
			if (have_frame) begin
				mean = frame_mean(done_sum);
				r.wv = hann_windowed(frame_store[rd], mean, pos);
				r.ov = 1'b1;
				r.fmin = done_min;
				r.fmax = done_max;
				r.mean = mean;
			end
			// Position and frame end are reported even while the output is invalid.
			r.pos = pos[POS_OUT_W-1:0];
			r.last = (pos == FRAME - 1);
			expected_results.push_back(r);

			frame_store[wr_pos] = s;
			run_sum = run_sum + 20'(s);
			if (s < run_min) run_min = s;
			if (s > run_max) run_max = s;
			// Frame end: the statistics including this sample become the reference frame.
			if (pos == FRAME - 1) begin
				done_sum = run_sum;
				done_min = run_min;
				done_max = run_max;
				run_sum = '0;
				run_min = '1;
				run_max = '0;
				have_frame = 1'b1;
			end
			wr_pos = (wr_pos + 1) % (2 * FRAME);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_result(window_result_t got);
			window_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transaction, expected none actual %p",
					$time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("windowed_value", 32'(want.wv), 32'(got.wv));
			compare_field("out_valid", 32'(want.ov), 32'(got.ov));
			compare_field("out_position", 32'(want.pos), 32'(got.pos));
			compare_field("frame_last", 32'(want.last), 32'(got.last));
			compare_field("frame_min", 32'(want.fmin), 32'(got.fmin));
			compare_field("frame_max", 32'(want.fmax), 32'(got.fmax));
			compare_field("frame_mean_q8", 32'(want.mean), 32'(got.mean));
		endfunction
	endclass

	// Every input of the block starts at a known value, with reset asserted.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [WV_W-1:0]      windowed_value;
	logic                 out_valid;
	logic [POS_OUT_W-1:0] out_position;
	logic                 frame_last;
	logic [STAT_W-1:0]    frame_min;
	logic [STAT_W-1:0]    frame_max;
	logic [MEAN_W-1:0]    frame_mean_q8;

	window_scoreboard sb = new();

	// Idling controls. A burst flag turns off the random waits on its side for a stretch.
	logic tx_burst = 1'b0;
	logic rx_burst = 1'b0;
	int   rx_hold = 0;
	int   rx_count = 0;
	int   idle_cycles = 0;

	adc_frame_window_conditioner u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.windowed_value (windowed_value),
		.out_valid      (out_valid),
		.out_position   (out_position),
		.frame_last     (frame_last),
		.frame_min      (frame_min),
		.frame_max      (frame_max),
		.frame_mean_q8  (frame_mean_q8)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Monitor: everything is sampled at the rising edge, where both channels' handshakes
	// complete. The same process runs the watchdog on cycles with no transaction at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) sb.note_sample(sample);
			if (result_valid && !result_stall) begin
				sb.check_result('{windowed_value, out_valid, out_position, frame_last,
					frame_min, frame_max, frame_mean_q8});
				// The receiver draws its stall for the next result here.
				rx_count++;
				if (rx_count % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
				rx_hold = rx_burst ? 0 : $urandom_range(0, 9);
			end
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Receiver: holds stall high for the drawn number of cycles after each result.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Sends one sample transaction after a random gap. Valid stays high across back-to-back
	// transactions, and the payload is held until the block takes it.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	// Holds off the sender until every predicted result has been delivered.
	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] draw_sample(sample_mix_t mix,
			logic [SAMPLE_W-1:0] level);
		int v;
		case (mix)
			MIX_FULL_SCALE: return '1;
			MIX_ZERO: return '0;
			MIX_RAILS: return $urandom_range(0, 1) ? '1 : '0;
			MIX_NARROW: begin
				v = int'(level) + int'($urandom_range(0, 30)) - 15;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
				return v[SAMPLE_W-1:0];
			end
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	initial begin
		logic [SAMPLE_W-1:0] directed [DIRECTED_COUNT];
		sample_mix_t         mix;
		logic [SAMPLE_W-1:0] level;
		int                  pick;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: both rails, alternating bit patterns, mid-scale neighbors and a
		// walking one. These all land in the first frame, so their results must come out
		// invalid; they are windowed later once the next frame reads them back.
		directed = '{12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'h001, 12'h800,
			12'h7FF, 12'hFFE, 12'h001, 12'h002, 12'h004, 12'h008, 12'h010, 12'h020,
			12'h040, 12'h080, 12'h100, 12'h200, 12'h400, 12'h800};
		foreach (directed[i]) send_sample(directed[i]);

		// Random part. The mix changes every 64 transactions, so frames get means and
		// spreads from flat zero up to full scale. Waits on the sending side switch off
		// for some 40-transaction stretches.
		mix = MIX_UNIFORM;
		level = '0;
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i % 64 == 0) begin
				pick = $urandom_range(0, 7);
				case (pick)
					4: mix = MIX_FULL_SCALE;
					5: mix = MIX_ZERO;
					6: mix = MIX_RAILS;
					7: mix = MIX_NARROW;
					default: mix = MIX_UNIFORM;
				endcase
				level = SAMPLE_W'($urandom_range(0, 4095));
			end
			if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
			// Once in the run the sender waits for the block to empty completely.
			if (i == RANDOM_COUNT / 2) drain_results();
			send_sample(draw_sample(mix, level));
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
